// ===== design/rrss_pkg.sv =====
// Package for the round-robin time-slice scheduler.
// Holds the status codes, controller states, result type and default sizes.
// It has no dependencies.
package rrss_pkg;

  localparam int unsigned DefaultRingDepth = 16;
  localparam int unsigned IdWidth          = 8;
  localparam int unsigned TimeWidth        = 16;
  localparam int unsigned EntryWidth       = IdWidth + TimeWidth;
  localparam logic [TimeWidth-1:0] QuantumReset = 16'd3;

  typedef enum logic [1:0] {
    StAdded = 2'd0,
    StRun   = 2'd1,
    StFull  = 2'd2,
    StEmpty = 2'd3
  } rrss_status_e;

  typedef enum logic {
    CtlIdle,
    CtlRead
  } rrss_state_e;

  typedef struct packed {
    rrss_status_e         status;
    logic [IdWidth-1:0]   served_id;
    logic [TimeWidth-1:0] run_time;
    logic [TimeWidth-1:0] time_left;
    logic                 finished;
  } rrss_result_t;

endpackage

// ===== design/round_robin_slice_scheduler_unit.sv =====
// Round-robin time-slice scheduler.
// A ring of jobs kept in one synchronous memory, with head, tail and count registers.
// Depends on rrss_pkg.
//
// Usage: items arrive on the s_axis channel. tuser carries the mode (0 adds the job
// in tdata, 1 runs one time slice on the job at the head of the ring). Every item
// yields exactly one result on the m_axis channel, whose tuser carries the status.
// The quantum register is written over the cfg channel, which is always ready and
// should only be used while no item is in flight.
// Flow: an add is accepted in the idle state and its result goes to the output
// register. A slice first reads the head entry out of the ring memory into a read
// register; in the read state that follows, the result is produced and an unfinished
// entry is written back at the tail. An empty-ring slice is answered from idle.
// One add is taken per cycle while s_axis_tready is high; a slice holds off new items.
// Reset empties the ring (count, head and tail cleared) and sets the quantum to 3;
// the memory itself is not cleared. A result waits in the output register while
// the receiver stalls; one further result can be held in a skid buffer, and
// s_axis_tready is low while that buffer is full or a slice is reading the ring.
module round_robin_slice_scheduler_unit
  import rrss_pkg::*;
#(
  parameter int unsigned RING_DEPTH = DefaultRingDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: job_id[7:0], burst_time[23:8].
  input  logic [23:0] s_axis_tdata,
  // Fields from bit 0: mode[0].
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: served_id[7:0], run_time[23:8], time_left[39:24],
  // finished[40], zero padding[47:41].
  output logic [47:0] m_axis_tdata,
  // Fields from bit 0: status[1:0].
  output logic [1:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned PtrWidth = $clog2(RING_DEPTH);
  localparam int unsigned CntWidth = $clog2(RING_DEPTH + 1);
  localparam logic [PtrWidth-1:0] LastSlot = PtrWidth'(RING_DEPTH - 1);
  localparam logic [CntWidth-1:0] FullCount = CntWidth'(RING_DEPTH);

  logic [EntryWidth-1:0] ring_mem [RING_DEPTH];
  logic [EntryWidth-1:0] rd_data_q;

  rrss_state_e           state_q, state_d;
  logic [PtrWidth-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CntWidth-1:0]   count_q, count_d;
  logic [TimeWidth-1:0]  quantum_q;

  rrss_result_t          out_q, hold_q, res;
  logic                  out_valid_q, hold_valid_q;
  logic                  res_valid;

  logic                  in_fire, out_fire;
  logic                  mem_we, mem_re;
  logic [PtrWidth-1:0]   mem_waddr;
  logic [EntryWidth-1:0] mem_wdata;
  logic [TimeWidth-1:0]  rem, run_amt, left_amt;

  assign s_axis_tready = (state_q == CtlIdle) && !hold_valid_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign rem      = rd_data_q[TimeWidth-1:0];
  assign run_amt  = (quantum_q < rem) ? quantum_q : rem;
  assign left_amt = rem - run_amt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CtlIdle;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = tail_q;
    mem_wdata = {s_axis_tdata[7:0], s_axis_tdata[23:8]};
    res_valid = 1'b0;
    res       = '{status: StAdded, served_id: '0, run_time: '0, time_left: '0,
                  finished: 1'b0};
    unique case (state_q)
      CtlIdle: begin
        if (in_fire) begin
          if (s_axis_tuser[0] == 1'b0) begin
            res_valid = 1'b1;
            if (count_q == FullCount) begin
              res.status = StFull;
            end else begin
              mem_we  = 1'b1;
              tail_d  = (tail_q == LastSlot) ? '0 : tail_q + 1'b1;
              count_d = count_q + 1'b1;
            end
          end else if (count_q == '0) begin
            res_valid  = 1'b1;
            res.status = StEmpty;
          end else begin
            mem_re  = 1'b1;
            state_d = CtlRead;
          end
        end
      end
      CtlRead: begin
        res_valid     = 1'b1;
        res.status    = StRun;
        res.served_id = rd_data_q[EntryWidth-1:TimeWidth];
        res.run_time  = run_amt;
        res.time_left = left_amt;
        head_d        = (head_q == LastSlot) ? '0 : head_q + 1'b1;
        if (left_amt != '0) begin
          mem_we    = 1'b1;
          mem_wdata = {rd_data_q[EntryWidth-1:TimeWidth], left_amt};
          tail_d    = (tail_q == LastSlot) ? '0 : tail_q + 1'b1;
        end else begin
          res.finished = 1'b1;
          count_d      = count_q - 1'b1;
        end
        state_d = CtlIdle;
      end
      default: state_d = CtlIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= ring_mem[head_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QuantumReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      quantum_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_fire) begin
        out_valid_q  <= hold_valid_q || res_valid;
        hold_valid_q <= 1'b0;
      end else if (res_valid) begin
        hold_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_fire) begin
      out_q <= hold_valid_q ? hold_q : res;
    end else if (res_valid) begin
      hold_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {7'b0, out_q.finished, out_q.time_left, out_q.run_time,
                          out_q.served_id};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCount)
    else $error("Job count exceeds ring depth.");

  a_hold_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_valid_q |-> out_valid_q)
    else $error("Skid buffer holds a result while the output register is empty.");

  a_read_follows_slice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CtlRead) |-> $past(in_fire && s_axis_tuser[0] && count_q != '0))
    else $error("Ring read without an accepted slice on a non-empty ring.");

  a_no_result_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && hold_valid_q) |-> 1'b0)
    else $error("New result produced while the skid buffer is occupied.");

  a_finished_zero_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[40]) |-> (m_axis_tdata[39:24] == '0
      && m_axis_tuser == StRun))
    else $error("Finished result with time left or wrong status.");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for round_robin_slice_scheduler_unit, with its own job-ring predictor.
// It runs a directed table, a drain at the largest quantum, then random add/slice phases under several quanta.
// Depends on rrss_pkg and the scheduler RTL.
module tb_top;
  import rrss_pkg::*;

  localparam int unsigned RingDepth = DefaultRingDepth;
  localparam logic ModeAdd = 1'b0;
  localparam logic ModeSlice = 1'b1;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned PhaseItems = 70;
  localparam int unsigned PressurePhase = 2;
  localparam int unsigned PressureHold = 150;

  localparam rrss_result_t NoneRes = '0;
  localparam rrss_result_t AddedRes = '{StAdded, 8'h00, 16'h0000, 16'h0000, 1'b0};
  localparam rrss_result_t FullRes = '{StFull, 8'h00, 16'h0000, 16'h0000, 1'b0};
  localparam rrss_result_t EmptyRes = '{StEmpty, 8'h00, 16'h0000, 16'h0000, 1'b0};
  localparam rrss_result_t ZeroBurstRes = '{StRun, 8'h00, 16'h0000, 16'h0000, 1'b1};

  typedef struct packed {
    logic         mode;
    logic [7:0]   id;
    logic [15:0]  burst;
    logic         typed;
    rrss_result_t want;
  } stim_row_t;

  // Starts empty, fills the ring to the brim with the quantum at its reset value.
  localparam stim_row_t DirectedRows [22] = '{
    '{ModeSlice, 8'h00, 16'h0000, 1'b1, EmptyRes},
    '{ModeAdd,   8'hFF, 16'hFFFF, 1'b1, AddedRes},
    '{ModeAdd,   8'h00, 16'h0000, 1'b1, AddedRes},
    '{ModeSlice, 8'h00, 16'h0000, 1'b0, NoneRes},
    '{ModeSlice, 8'hFF, 16'hFFFF, 1'b1, ZeroBurstRes},
    '{ModeAdd,   8'h01, 16'h0001, 1'b1, AddedRes},
    '{ModeAdd,   8'h02, 16'h0002, 1'b1, AddedRes},
    '{ModeAdd,   8'h04, 16'h0004, 1'b1, AddedRes},
    '{ModeAdd,   8'h08, 16'h0008, 1'b1, AddedRes},
    '{ModeAdd,   8'h10, 16'h0010, 1'b1, AddedRes},
    '{ModeAdd,   8'h20, 16'h0020, 1'b1, AddedRes},
    '{ModeAdd,   8'h40, 16'h0040, 1'b1, AddedRes},
    '{ModeAdd,   8'h80, 16'h0080, 1'b1, AddedRes},
    '{ModeAdd,   8'h55, 16'h0100, 1'b1, AddedRes},
    '{ModeAdd,   8'hAA, 16'h0200, 1'b1, AddedRes},
    '{ModeAdd,   8'h0F, 16'h0400, 1'b1, AddedRes},
    '{ModeAdd,   8'hF0, 16'h0800, 1'b1, AddedRes},
    '{ModeAdd,   8'h33, 16'h1000, 1'b1, AddedRes},
    '{ModeAdd,   8'hCC, 16'h2000, 1'b1, AddedRes},
    '{ModeAdd,   8'h7E, 16'h4000, 1'b1, AddedRes},
    '{ModeAdd,   8'h81, 16'h8000, 1'b1, FullRes},
    '{ModeSlice, 8'h00, 16'h0000, 1'b0, NoneRes}
  };

  localparam logic [15:0] PhaseQuantum [NumPhases] = '{16'd1, 16'd0, 16'd7, 16'd0, 16'hFFFF, 16'd2};
  localparam int unsigned PhaseAddPct [NumPhases] = '{50, 75, 40, 55, 30, 60};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  logic [23:0]  shadow_ring [RingDepth];
  int unsigned  ring_head = 0;
  int unsigned  ring_tail = 0;
  int unsigned  held_jobs = 0;
  logic [15:0]  quantum_q = QuantumReset;
  rrss_result_t sched_expect_q [$];

  bit          sender_calm = 1'b0;
  bit          receiver_calm = 1'b0;
  int unsigned long_hold = 0;
  int unsigned mismatches = 0;
  int unsigned seen_added = 0;
  int unsigned seen_run = 0;
  int unsigned seen_finished = 0;
  int unsigned seen_full = 0;
  int unsigned seen_empty = 0;

  round_robin_slice_scheduler_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic rrss_result_t schedule_step(input logic mode, input logic [7:0] id,
                                                 input logic [15:0] burst);
    rrss_result_t res;
    logic [23:0]  entry;
    logic [15:0]  remaining;
    res = '0;
    res.status = StAdded;
    if (mode == ModeAdd) begin
      if (held_jobs >= RingDepth) begin
        res.status = StFull;
      end else begin
        shadow_ring[ring_tail] = {id, burst};
        ring_tail = (ring_tail + 1) % RingDepth;
        held_jobs++;
      end
    end else if (held_jobs == 0) begin
      res.status = StEmpty;
    end else begin
      entry = shadow_ring[ring_head];
      remaining = entry[15:0];
      res.status = StRun;
      res.served_id = entry[23:16];
      res.run_time = (quantum_q < remaining) ? quantum_q : remaining;
      res.time_left = remaining - res.run_time;
      ring_head = (ring_head + 1) % RingDepth;
      if (res.time_left != 0) begin
        shadow_ring[ring_tail] = {res.served_id, res.time_left};
        ring_tail = (ring_tail + 1) % RingDepth;
      end else begin
        held_jobs--;
        res.finished = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string field, input int unsigned got,
                               input int unsigned want);
    $display("mismatch in %s at %0t: got 0x%0h, expected 0x%0h", field, $time, got, want);
    mismatches++;
  endtask

  task automatic offer_item(input logic mode, input logic [7:0] id, input logic [15:0] burst,
                            input logic typed, input rrss_result_t want);
    int unsigned  gap;
    rrss_result_t predicted;
    gap = sender_calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {burst, id};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = schedule_step(mode, id, burst);
    sched_expect_q.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  task automatic offer_random(input int unsigned add_pct);
    logic        mode;
    logic [15:0] burst;
    mode = ($urandom_range(0, 99) < add_pct) ? ModeAdd : ModeSlice;
    burst = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 12)) : 16'($urandom);
    offer_item(mode, 8'($urandom), burst, 1'b0, NoneRes);
  endtask

  // Drains every outstanding result, lets the slice pipeline settle, then loads a quantum.
  task automatic settle_and_load(input logic [15:0] quantum);
    s_axis_tvalid <= 1'b0;
    while (sched_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= quantum;
    do @(posedge clk_i); while (!cfg_ready_o);
    quantum_q = quantum;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned stall;
    rrss_result_t want;
    rrss_status_e got_status;
    logic [7:0]   got_id;
    logic [15:0]  got_run;
    logic [15:0]  got_left;
    logic         got_fin;
    @(posedge rst_ni);
    forever begin
      stall = receiver_calm ? 0 : $urandom_range(0, 11);
      if (long_hold != 0) begin
        stall = long_hold;
        long_hold = 0;
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got_status = rrss_status_e'(m_axis_tuser);
      got_id = m_axis_tdata[7:0];
      got_run = m_axis_tdata[23:8];
      got_left = m_axis_tdata[39:24];
      got_fin = m_axis_tdata[40];
      case (got_status)
        StAdded: seen_added++;
        StRun: begin
          seen_run++;
          if (got_fin) seen_finished++;
        end
        StFull: seen_full++;
        default: seen_empty++;
      endcase
      if (sched_expect_q.size() == 0) begin
        flag_mismatch("unexpected result status", got_status, 0);
      end else begin
        want = sched_expect_q.pop_front();
        if (got_status !== want.status) flag_mismatch("status", got_status, want.status);
        if (got_id !== want.served_id) flag_mismatch("served_id", got_id, want.served_id);
        if (got_run !== want.run_time) flag_mismatch("run_time", got_run, want.run_time);
        if (got_left !== want.time_left) flag_mismatch("time_left", got_left, want.time_left);
        if (got_fin !== want.finished) flag_mismatch("finished", got_fin, want.finished);
      end
      @(negedge clk_i);
    end
  end

  initial begin
    logic [15:0] quantum;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DirectedRows[i]) begin
      offer_item(DirectedRows[i].mode, DirectedRows[i].id, DirectedRows[i].burst,
                 DirectedRows[i].typed, DirectedRows[i].want);
    end

    // With the largest quantum every slice finishes its job, down to the last one and past it.
    settle_and_load(16'hFFFF);
    repeat (RingDepth + 1) offer_item(ModeSlice, 8'($urandom), 16'($urandom), 1'b0, NoneRes);

    for (int unsigned p = 0; p < NumPhases; p++) begin
      quantum = (p == 3) ? 16'($urandom_range(1, 65535)) : PhaseQuantum[p];
      settle_and_load(quantum);
      sender_calm = ($urandom_range(0, 2) == 0);
      receiver_calm = ($urandom_range(0, 2) == 0);
      if (p == PressurePhase) begin
        sender_calm = 1'b1;
        long_hold = PressureHold;
      end
      repeat (PhaseItems) offer_random(PhaseAddPct[p]);
    end

    s_axis_tvalid <= 1'b0;
    while (sched_expect_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Covered %0d adds, %0d slices with %0d jobs finished,", seen_added, seen_run,
             seen_finished);
    $display("%0d adds to a full ring and %0d slices on an empty one.", seen_full, seen_empty);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timed out with %0d results outstanding.", sched_expect_q.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
